// ===== hdl/lrto_pkg.sv =====
// Package for the lidar ring yaw time offset block.
// Types, register indexes, CORDIC arctangent table and sequencer states.
// No dependencies.
package lrto_pkg;

  localparam int RINGS     = 64;
  localparam int RING_W    = 6;
  localparam int TIME_W    = 20;
  localparam int YAW_W     = 16;
  localparam int CORD_IT   = 16;
  localparam int CORD_W    = 32;
  localparam int ANG_W     = 26;

  localparam logic [TIME_W-1:0] TIME_MAX   = 20'hFFFFF;
  localparam logic [16:0]       TURN_UNITS = 17'd46080;
  localparam logic [ANG_W-1:0]  HALF_TURN  = 26'd11796480;

  localparam logic [1:0] REG_BLIND = 2'd0;
  localparam logic [1:0] REG_DEC   = 2'd1;
  localparam logic [1:0] REG_MSPD  = 2'd2;
  localparam logic [1:0] REG_TSCL  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_PTIME,
    ST_CORDIC,
    ST_LOOKUP,
    ST_LAG,
    ST_TURN,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [18:0] x;
    logic [18:0] y;
  } cord_req_t;

  typedef struct packed {
    logic done;
    logic signed [YAW_W-1:0] yaw;
  } cord_rsp_t;

  function automatic logic [ANG_W-1:0] atan_q16(input logic [3:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      4'd0:  v = 26'd2949120;
      4'd1:  v = 26'd1740967;
      4'd2:  v = 26'd919879;
      4'd3:  v = 26'd466945;
      4'd4:  v = 26'd234379;
      4'd5:  v = 26'd117304;
      4'd6:  v = 26'd58666;
      4'd7:  v = 26'd29335;
      4'd8:  v = 26'd14668;
      4'd9:  v = 26'd7334;
      4'd10: v = 26'd3667;
      4'd11: v = 26'd1833;
      4'd12: v = 26'd917;
      4'd13: v = 26'd458;
      4'd14: v = 26'd229;
      4'd15: v = 26'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lrto_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module lrto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lrto_cordic.sv =====
// Iterative CORDIC vectoring unit: azimuth in 1/128 degree, one step a cycle.
// Depends on lrto_pkg.
module lrto_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  lrto_pkg::cord_req_t req,
  output lrto_pkg::cord_rsp_t rsp
);
  logic signed [lrto_pkg::CORD_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [lrto_pkg::ANG_W-1:0]  z_r, z_nxt;
  logic [3:0] it_r, it_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [lrto_pkg::CORD_W-1:0] xs, ys, xi, yi;
  logic signed [lrto_pkg::ANG_W-1:0]  zr;
  logic signed [lrto_pkg::YAW_W-1:0]  yaw_r, yaw_nxt;
  logic zero;

  always_comb begin
    xi = {{(lrto_pkg::CORD_W-29){req.x[18]}}, req.x, 10'd0};
    yi = {{(lrto_pkg::CORD_W-29){req.y[18]}}, req.y, 10'd0};
    zero = (req.x == '0) && (req.y == '0);
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    it_nxt = it_r; busy_nxt = busy_r; done_nxt = 1'b0;
    yaw_nxt = yaw_r;
    zr = z_r + lrto_pkg::ANG_W'(256);
    if (req.start) begin
      if (zero) begin
        yaw_nxt = '0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        it_nxt = '0;
        if (xi < 0) begin
          x_nxt = -xi; y_nxt = -yi;
          z_nxt = (yi >= 0) ? $signed(lrto_pkg::HALF_TURN) : -$signed(lrto_pkg::HALF_TURN);
        end else begin
          x_nxt = xi; y_nxt = yi; z_nxt = '0;
        end
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs;
        z_nxt = z_r + $signed(lrto_pkg::atan_q16(it_r));
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs;
        z_nxt = z_r - $signed(lrto_pkg::atan_q16(it_r));
      end
      if (it_r == 4'(lrto_pkg::CORD_IT - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        it_nxt = it_r + 4'd1;
      end
    end else if (it_r == 4'(lrto_pkg::CORD_IT - 1) && !done_r) begin
      yaw_nxt = zr[lrto_pkg::ANG_W-2:9];
      done_nxt = 1'b1;
      it_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; yaw_r <= yaw_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.yaw  = yaw_r;
endmodule

// ===== hdl/lidar_ring_yaw_time_offset.sv =====
// Top level of the lidar point time offset block.
// Depends on lrto_pkg, lrto_cordic and lrto_ram.
//
// One point is taken at a time; in_tready is low while it is worked. A point
// with a sensor time needs one scaling product; an azimuth point also waits
// for the 16-step CORDIC loop, skipped when x and y are both zero. The single
// shared 32x32 multiplier forms the squared range and the time products. The
// result sits in an output register, and the next point is accepted once it
// has been taken, in the cycle after the result transfer at the earliest.
module lidar_ring_yaw_time_offset (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[18:0], pos_y[37:19], pos_z[56:38], intensity[72:57],
  // ring[78:73], point_time[98:79], zero pad
  input  logic [103:0] in_tdata,
  // has_point_time[0], frame_start[1]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_x[18:0], out_y[37:19], out_z[56:38], out_intensity[72:57],
  // offset_time[92:73], zero pad
  output logic [95:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [37:0] cfg_data
);
  lrto_pkg::state_t st_r, st_nxt;
  logic [37:0] blind_r;
  logic [7:0]  dec_r, idx_r, idx_nxt;
  logic [19:0] mspd_r;
  logic [23:0] tscl_r;
  logic [lrto_pkg::RINGS-1:0] seen_r, seen_nxt;
  logic [103:0] pt_r;
  logic [1:0]  usr_r;
  logic keep_r, keep_nxt, drop_r, drop_nxt;
  logic [39:0] rsq_r, rsq_nxt;
  logic [19:0] t_r, t_nxt;
  logic [20:0] tt_r, tt_nxt;
  logic [19:0] last_q;
  logic signed [15:0] first_q;
  logic [95:0] od_r, od_nxt;
  logic ov_r, ov_nxt;
  logic [31:0] ma, mb;
  logic [63:0] mp;
  logic [63:0] turn_p;
  logic signed [18:0] sx, sy, sz;
  logic [5:0] ring;
  logic we_yaw, we_last;
  logic [15:0] wyaw;
  logic [19:0] wlast;
  lrto_pkg::cord_req_t creq;
  lrto_pkg::cord_rsp_t crsp;
  logic signed [17:0] d;
  logic [7:0] dec_eff, idx_base;
  logic [50:0] tmp;

  assign sx = pt_r[18:0];
  assign sy = pt_r[37:19];
  assign sz = pt_r[56:38];
  assign ring = pt_r[78:73];

  lrto_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  lrto_ram #(.WIDTH(16), .DEPTH(lrto_pkg::RINGS)) u_yaw (
    .clk(clk), .we(we_yaw), .waddr(ring), .wdata(wyaw), .raddr(ring), .rdata(first_q));
  lrto_ram #(.WIDTH(20), .DEPTH(lrto_pkg::RINGS)) u_last (
    .clk(clk), .we(we_last), .waddr(ring), .wdata(wlast), .raddr(ring), .rdata(last_q));

  assign mp = ma * mb;
  assign in_tready = (st_r == lrto_pkg::ST_IDLE) && !ov_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; seen_nxt = seen_r;
    keep_nxt = keep_r; drop_nxt = drop_r; rsq_nxt = rsq_r;
    t_nxt = t_r; tt_nxt = tt_r; od_nxt = od_r; ov_nxt = ov_r;
    ma = '0; mb = '0;
    creq.start = 1'b0; creq.x = sx; creq.y = sy;
    we_yaw = 1'b0; we_last = 1'b0; wyaw = crsp.yaw; wlast = '0;
    d = '0; tmp = '0; turn_p = '0;
    dec_eff = (dec_r == 8'd0) ? 8'd1 : dec_r;
    idx_base = in_tuser[1] ? 8'd0 : idx_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      lrto_pkg::ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser[1]) seen_nxt = '0;
          keep_nxt = (idx_base == 8'd0);
          idx_nxt = (9'(idx_base) + 9'd1 >= 9'(dec_eff)) ? 8'd0 : idx_base + 8'd1;
          drop_nxt = 1'b0; rsq_nxt = '0; t_nxt = '0;
          st_nxt = lrto_pkg::ST_SQX;
        end
      end
      lrto_pkg::ST_SQX: begin
        ma = 32'(unsigned'(sx < 0 ? -sx : sx)); mb = ma;
        rsq_nxt = rsq_r + 40'(mp);
        st_nxt = lrto_pkg::ST_SQY;
      end
      lrto_pkg::ST_SQY: begin
        ma = 32'(unsigned'(sy < 0 ? -sy : sy)); mb = ma;
        rsq_nxt = rsq_r + 40'(mp);
        st_nxt = lrto_pkg::ST_SQZ;
      end
      lrto_pkg::ST_SQZ: begin
        ma = 32'(unsigned'(sz < 0 ? -sz : sz)); mb = ma;
        rsq_nxt = rsq_r + 40'(mp);
        if (usr_r[0]) st_nxt = lrto_pkg::ST_PTIME;
        else if (32'(ring) >= lrto_pkg::RINGS) begin
          drop_nxt = 1'b1; st_nxt = lrto_pkg::ST_FINISH;
        end else begin
          creq.start = 1'b1; st_nxt = lrto_pkg::ST_CORDIC;
        end
      end
      lrto_pkg::ST_PTIME: begin
        ma = 32'(pt_r[98:79]); mb = 32'(tscl_r);
        tmp = 51'(mp) + 51'd32768;
        t_nxt = (tmp[50:16] > 35'(lrto_pkg::TIME_MAX)) ? lrto_pkg::TIME_MAX : tmp[35:16];
        st_nxt = lrto_pkg::ST_FINISH;
      end
      lrto_pkg::ST_CORDIC: begin
        if (crsp.done) st_nxt = lrto_pkg::ST_LOOKUP;
      end
      lrto_pkg::ST_LOOKUP: begin
        if (!seen_r[ring]) begin
          seen_nxt[ring] = 1'b1; we_yaw = 1'b1; we_last = 1'b1; wlast = '0;
          drop_nxt = 1'b1; st_nxt = lrto_pkg::ST_FINISH;
        end else begin
          st_nxt = lrto_pkg::ST_LAG;
        end
      end
      lrto_pkg::ST_LAG: begin
        d = 18'(first_q) - 18'(crsp.yaw);
        if (crsp.yaw > first_q) d = d + 18'(lrto_pkg::TURN_UNITS);
        ma = 32'(unsigned'(d)); mb = 32'(mspd_r);
        tmp = 51'(mp) + 51'd4096;
        tt_nxt = (tmp[50:13] > 38'h1FFFFF) ? 21'h1FFFFF : tmp[33:13];
        st_nxt = lrto_pkg::ST_TURN;
      end
      lrto_pkg::ST_TURN: begin
        ma = 32'(lrto_pkg::TURN_UNITS); mb = 32'(mspd_r);
        turn_p = (mp + 64'd4096) >> 13;
        tmp = 51'(tt_r);
        if (tt_r < 21'(last_q)) tmp = tmp + 51'(turn_p);
        t_nxt = (tmp > 51'(lrto_pkg::TIME_MAX)) ? lrto_pkg::TIME_MAX : tmp[19:0];
        we_last = 1'b1; wlast = t_nxt;
        st_nxt = lrto_pkg::ST_FINISH;
      end
      lrto_pkg::ST_FINISH: begin
        if (!drop_r && keep_r && rsq_r > 40'(blind_r)) st_nxt = lrto_pkg::ST_OUT;
        else st_nxt = lrto_pkg::ST_IDLE;
      end
      lrto_pkg::ST_OUT: begin
        if (!ov_r) begin
          od_nxt = {3'd0, t_r, pt_r[72:0]};
          ov_nxt = 1'b1;
          st_nxt = lrto_pkg::ST_IDLE;
        end
      end
      default: st_nxt = lrto_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lrto_pkg::ST_IDLE;
      idx_r <= '0; seen_r <= '0; ov_r <= 1'b0;
      blind_r <= 38'd105; dec_r <= 8'd1; mspd_r <= 20'd18157; tscl_r <= 24'd67109;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; seen_r <= seen_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lrto_pkg::REG_BLIND: blind_r <= cfg_data;
          lrto_pkg::REG_DEC:   dec_r <= cfg_data[7:0];
          lrto_pkg::REG_MSPD:  mspd_r <= cfg_data[19:0];
          lrto_pkg::REG_TSCL:  tscl_r <= cfg_data[23:0];
          default: ;
        endcase
      end
    end
    if (in_tvalid && in_tready) begin
      pt_r <= in_tdata; usr_r <= in_tuser;
    end
    keep_r <= keep_nxt; drop_r <= drop_nxt; rsq_r <= rsq_nxt;
    t_r <= t_nxt; tt_r <= tt_nxt; od_r <= od_nxt;
  end
endmodule

// ===== hdl/lrto_checker.sv =====
// Port-level checker for the lidar time offset block, bound to the top level.
// Depends on lidar_ring_yaw_time_offset ports only.
module lrto_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:93] == 3'd0)
    else $error("pad bits set");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted while busy");
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result too early");
endmodule

bind lidar_ring_yaw_time_offset lrto_checker u_lrto_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
